// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/hgp_pkg.sv =====
// ----------------------------------------------------------------------------
// hgp_pkg
// phase and status codes, character constants and result type of the parser
// ----------------------------------------------------------------------------
package hgp_pkg;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_G    = 5'd1,
        PH_E    = 5'd2,
        PH_T    = 5'd3,
        PH_SP   = 5'd4,
        PH_URI  = 5'd5,
        PH_V0   = 5'd6,
        PH_V1   = 5'd7,
        PH_V2   = 5'd8,
        PH_V3   = 5'd9,
        PH_V4   = 5'd10,
        PH_V5   = 5'd11,
        PH_V6   = 5'd12,
        PH_V7   = 5'd13,
        PH_SKIP = 5'd14,
        PH_CR1  = 5'd15,
        PH_LF1  = 5'd16,
        PH_CR2  = 5'd17
    } phase_t;

    typedef enum logic [2:0] {
        ST_PARSING = 3'd0,
        ST_ACCEPT  = 3'd1,
        ST_BAD     = 3'd2,
        ST_LONG    = 3'd3,
        ST_IDLE    = 3'd4
    } status_t;

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;

    typedef struct packed {
        status_t    status;
        logic       uri_valid;
        logic [7:0] uri_index;
        logic [7:0] uri_byte;
    } result_t;

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_H;
            3'd1:    ch = CH_T;
            3'd2:    ch = CH_T;
            3'd3:    ch = CH_P;
            3'd4:    ch = CH_SLASH;
            3'd5:    ch = CH_ONE;
            3'd6:    ch = CH_DOT;
            default: ch = CH_ONE;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/http_get_request_parser.sv =====
// ----------------------------------------------------------------------------
// http_get_request_parser
// byte-wide http/1.1 get request line parser with uri extraction
// ----------------------------------------------------------------------------
// Request bytes enter on the s_ stream: s_tdata carries the byte, s_tuser
// marks the first byte of a new connection and restarts the parser, s_tlast
// marks the close of the stream (its data byte is ignored). Every request
// byte gives exactly one result on the m_ stream: a status code and, for bytes
// of the uri, the uri byte and its index.
// An accepted request byte passes the input register, then the decode logic
// into the result register, before its result shows on m_tvalid. Throughput
// is one byte per cycle while m_tready holds; the byte decision is
// a single pass of compare logic against the parse phase register.
// Reset clears both registers' valid flags and puts the parser in its idle
// phase, where bytes give the idle status until s_tuser marks a new request.
// When the receiver stalls, the result holds in the output register, the
// input register fills behind it, and s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module http_get_request_parser
    import hgp_pkg::*;
#(
    parameter int URI_MAX_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] new_request
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [10:3] uri_index, [18:11] uri_byte
    output logic        m_tuser    // [0] uri_valid
);

    localparam int CW = $clog2(URI_MAX_LEN + 1);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_new_reg;
    logic          in_end_reg;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_res_reg, res_next;
    logic          advance;
    logic          s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    hgp_step #(
        .URI_MAX_LEN (URI_MAX_LEN)
    ) u_step (
        .phase       (phase_reg),
        .count       (count_reg),
        .data_byte   (in_byte_reg),
        .new_request (in_new_reg),
        .stream_end  (in_end_reg),
        .phase_next  (phase_next),
        .count_next  (count_next),
        .result      (res_next)
    );

    always_comb begin
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_new_reg  <= s_tuser;
            in_end_reg  <= s_tlast;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.uri_valid;
    assign m_tdata  = {5'd0, out_res_reg.uri_byte, out_res_reg.uri_index,
                       out_res_reg.status};

    `ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(URI_MAX_LEN))
    `ASSERT_IMP(a_uri_parsing, aclk, aresetn, out_valid_reg && out_res_reg.uri_valid,
        out_res_reg.status == ST_PARSING)
    `ASSERT_NXT(a_final_idle, aclk, aresetn,
        advance && (res_next.status == ST_ACCEPT || res_next.status == ST_BAD ||
                    res_next.status == ST_LONG),
        phase_reg == PH_IDLE)
    `ASSERT_NXT(a_phase_hold, aclk, aresetn, !advance,
        $stable(phase_reg) && $stable(count_reg))

endmodule

// ===== src/hgp_step.sv =====
// ----------------------------------------------------------------------------
// hgp_step
// decides one request byte against the current phase and uri count
// ----------------------------------------------------------------------------
module hgp_step
    import hgp_pkg::*;
#(
    parameter int URI_MAX_LEN = 255
) (
    input  phase_t                             phase,
    input  logic [$clog2(URI_MAX_LEN+1)-1:0]   count,
    input  logic [7:0]                         data_byte,
    input  logic                               new_request,
    input  logic                               stream_end,
    output phase_t                             phase_next,
    output logic [$clog2(URI_MAX_LEN+1)-1:0]   count_next,
    output result_t                            result
);

    localparam int CW = $clog2(URI_MAX_LEN + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(URI_MAX_LEN);

    phase_t          cur_phase;
    logic [CW-1:0]   cur_count;
    logic [CW+7:0]   count_ext;
    logic [7:0]      want;
    logic [2:0]      ver_pos;
    logic [4:0]      phase_inc;

    assign cur_phase = new_request ? PH_G : phase;
    assign cur_count = new_request ? '0 : count;
    assign count_ext = {8'd0, cur_count};
    assign ver_pos   = 3'(cur_phase - PH_V0);
    assign phase_inc = cur_phase + 5'd1;

    always_comb begin
        case (cur_phase)
            PH_G:    want = CH_G;
            PH_E:    want = CH_E;
            PH_T:    want = CH_T;
            default: want = CH_SPACE;
        endcase
    end

    always_comb begin
        phase_next       = cur_phase;
        count_next       = cur_count;
        result.status    = ST_PARSING;
        result.uri_valid = 1'b0;
        result.uri_index = 8'd0;
        result.uri_byte  = 8'd0;
        if (cur_phase == PH_IDLE) begin
            result.status = ST_IDLE;
        end else if (stream_end) begin
            result.status = ST_BAD;
            phase_next    = PH_IDLE;
        end else begin
            case (cur_phase)
                PH_G, PH_E, PH_T, PH_SP: begin
                    if (data_byte == want) begin
                        phase_next = phase_t'(phase_inc);
                    end else begin
                        result.status = ST_BAD;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_URI: begin
                    if (data_byte == CH_SPACE) begin
                        phase_next = PH_V0;
                    end else if (cur_count >= MAX_COUNT) begin
                        result.status = ST_LONG;
                        phase_next    = PH_IDLE;
                    end else begin
                        result.uri_valid = 1'b1;
                        result.uri_index = count_ext[7:0];
                        result.uri_byte  = data_byte;
                        count_next       = cur_count + 1'b1;
                    end
                end
                PH_V0, PH_V1, PH_V2, PH_V3, PH_V4, PH_V5, PH_V6, PH_V7: begin
                    if (data_byte == version_char(ver_pos)) begin
                        phase_next = phase_t'(phase_inc);
                    end else begin
                        result.status = ST_BAD;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_SKIP: begin
                    if (data_byte == CH_CR) begin
                        phase_next = PH_CR1;
                    end
                end
                PH_CR1: begin
                    if (data_byte == CH_LF) begin
                        phase_next = PH_LF1;
                    end else if (data_byte == CH_CR) begin
                        phase_next = PH_CR1;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_LF1: begin
                    phase_next = (data_byte == CH_CR) ? PH_CR2 : PH_SKIP;
                end
                PH_CR2: begin
                    if (data_byte == CH_LF) begin
                        result.status = ST_ACCEPT;
                        phase_next    = PH_IDLE;
                    end else if (data_byte == CH_CR) begin
                        phase_next = PH_CR1;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                default: begin
                    result.status = ST_IDLE;
                    phase_next    = PH_IDLE;
                end
            endcase
        end
    end

endmodule
